// ===== rtl/core/pfi_pkg.sv =====
package pfi_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int TAG_W          = 20;
    localparam int STATUS_W       = 3;
    localparam int SEED_W         = 16;

    localparam logic [SEED_W-1:0] SEED_DEFAULT = 16'hACE1;
    localparam logic [SEED_W-1:0] LFSR_TAPS    = 16'hB400;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DOMINATED = 3'd1,
        ST_TIE_KEPT  = 3'd2,
        ST_FULL      = 3'd3,
        ST_ENTRY     = 3'd4
    } status_t;

    // Front to back control
    typedef struct packed {
        logic valid;
        logic is_readout;
    } item_ctl_t;

endpackage

// ===== rtl/core/pfi_if.sv =====
interface pfi_req_if #(
    parameter int DW = pfi_pkg::DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [DW-1:0]         key_a;
    logic signed [DW-1:0]         key_b;
    logic signed [DW-1:0]         value_a;
    logic signed [DW-1:0]         value_b;
    logic [pfi_pkg::TAG_W-1:0]    tag;

    modport source (output valid, op, key_a, key_b, value_a, value_b, tag, input ready);
    modport sink   (input valid, op, key_a, key_b, value_a, value_b, tag, output ready);
endinterface

interface pfi_rsp_if #(
    parameter int DW    = pfi_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W = $clog2(pfi_pkg::CAPACITY_DEF + 1)
) ();
    logic                         valid;
    logic                         ready;
    logic [pfi_pkg::STATUS_W-1:0] status;
    logic [CNT_W-1:0]             count;
    logic signed [DW-1:0]         out_key_a;
    logic signed [DW-1:0]         out_key_b;
    logic signed [DW-1:0]         out_value_a;
    logic signed [DW-1:0]         out_value_b;
    logic [pfi_pkg::TAG_W-1:0]    out_tag;
    logic                         last;

    modport source (output valid, status, count, out_key_a, out_key_b, out_value_a,
                    out_value_b, out_tag, last, input ready);
    modport sink   (input valid, status, count, out_key_a, out_key_b, out_value_a,
                    out_value_b, out_tag, last, output ready);
endinterface

interface pfi_cfg_if ();
    logic                          valid;
    logic                          ready;
    logic [pfi_pkg::SEED_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/pfi_front.sv =====
module pfi_front #(
    parameter int DATA_WIDTH = pfi_pkg::DATA_WIDTH_DEF,
    parameter int ITEM_W     = 4 * DATA_WIDTH + pfi_pkg::TAG_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_op,
    input  logic [ITEM_W-1:0]     in_data,
    output pfi_pkg::item_ctl_t    item_ctl,
    output logic [ITEM_W-1:0]     item_data,
    input  logic                  item_pop
);

    // two-word queue between front and back
    logic [ITEM_W-1:0] q_data_reg [2];
    logic              q_read_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        fill_reg, fill_next;
    logic              push;
    logic              pop;

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = item_pop && (fill_reg != 2'd0);

    assign item_ctl.valid      = (fill_reg != 2'd0);
    assign item_ctl.is_readout = q_read_reg[rd_ptr_reg];
    assign item_data           = q_data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // classify on entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= in_data;
            q_read_reg[wr_ptr_reg] <= (in_op == pfi_pkg::OP_READOUT);
        end
    end

endmodule

// ===== rtl/core/pfi_back.sv =====
module pfi_back #(
    parameter int CAPACITY   = pfi_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pfi_pkg::DATA_WIDTH_DEF,
    parameter int ITEM_W     = 4 * DATA_WIDTH + pfi_pkg::TAG_W,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfi_pkg::item_ctl_t             item_ctl,
    input  logic [ITEM_W-1:0]              item_data,
    output logic                           item_pop,
    input  logic                           cfg_valid,
    input  logic [pfi_pkg::SEED_W-1:0]     cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pfi_pkg::STATUS_W-1:0]   out_status,
    output logic [CNT_W-1:0]               out_count,
    output logic [ITEM_W-1:0]              out_data,
    output logic                           out_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW = DATA_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_EV, S_RESP, S_RO_RD, S_RO_EV
    } state_t;

    // two banks; a walk reads one and writes the survivors into the other
    logic [ITEM_W-1:0] mem [2**(AW+1)];
    logic [ITEM_W-1:0] rdata_reg;
    logic [AW:0]       rd_addr;
    logic              we;
    logic [AW:0]       wr_addr;
    logic [ITEM_W-1:0] wdata;

    state_t                      state_reg, state_next;
    logic                        bank_reg, bank_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CNT_W-1:0]            r_reg, r_next;
    logic [CNT_W-1:0]            w_reg, w_next;
    logic                        done_reg, done_next;
    logic [pfi_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [pfi_pkg::SEED_W-1:0]  lfsr_reg, lfsr_next;
    logic [ITEM_W-1:0]           item_reg, item_next;
    logic                        ov_reg, ov_next;
    logic [pfi_pkg::STATUS_W-1:0] os_reg, os_next;
    logic [CNT_W-1:0]            oc_reg, oc_next;
    logic [ITEM_W-1:0]           od_reg, od_next;
    logic                        ol_reg, ol_next;

    logic signed [DW-1:0] na, nb, ea, eb;
    logic                 out_free;
    logic [CNT_W:0]       fill_now;

    assign na = item_reg[ITEM_W-1 -: DW];
    assign nb = item_reg[ITEM_W-1-DW -: DW];
    assign ea = rdata_reg[ITEM_W-1 -: DW];
    assign eb = rdata_reg[ITEM_W-1-DW -: DW];

    assign out_free = !ov_reg || out_ready;
    assign rd_addr  = {bank_reg, r_reg[AW-1:0]};
    assign fill_now = {1'b0, w_reg} + {1'b0, cnt_reg} - {1'b0, r_reg};

    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_count  = oc_reg;
    assign out_data   = od_reg;
    assign out_last   = ol_reg;

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        done_next  = done_reg;
        st_next    = st_reg;
        lfsr_next  = lfsr_reg;
        item_next  = item_reg;
        ov_next    = ov_reg && !out_ready;
        os_next    = os_reg;
        oc_next    = oc_reg;
        od_next    = od_reg;
        ol_next    = ol_reg;
        item_pop   = 1'b0;
        we         = 1'b0;
        wr_addr    = {~bank_reg, w_reg[AW-1:0]};
        wdata      = rdata_reg;

        if (cfg_valid)
        begin
            lfsr_next = (cfg_data == '0) ? pfi_pkg::SEED_DEFAULT : cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_ctl.valid)
                begin
                    item_pop  = 1'b1;
                    item_next = item_data;
                    r_next    = '0;
                    w_next    = '0;
                    done_next = 1'b0;
                    if (item_ctl.is_readout)
                    begin
                        state_next = (cnt_reg == '0) ? S_IDLE : S_RO_RD;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (r_reg == cnt_reg)
                begin
                    // walk finished without a verdict: append at the end
                    if (!done_reg)
                    begin
                        if ({1'b0, w_reg} >= (CNT_W+1)'(CAPACITY))
                        begin
                            st_next = pfi_pkg::ST_FULL;
                        end
                        else
                        begin
                            we      = 1'b1;
                            wdata   = item_reg;
                            w_next  = w_reg + 1'b1;
                            st_next = pfi_pkg::ST_INSERTED;
                        end
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_EV;
                end
            end
            S_EV:
            begin
                state_next = S_RD;
                if (done_reg)
                begin
                    // copy the tail
                    we     = 1'b1;
                    w_next = w_reg + 1'b1;
                    r_next = r_reg + 1'b1;
                end
                else if (ea <= na)
                begin
                    if (eb <= nb)
                    begin
                        if (ea == na && eb == nb)
                        begin
                            lfsr_next = (lfsr_reg >> 1)
                                      ^ (lfsr_reg[0] ? pfi_pkg::LFSR_TAPS : '0);
                        end
                        if (ea == na && eb == nb && lfsr_reg[0])
                        begin
                            we        = 1'b1;
                            w_next    = w_reg + 1'b1;
                            r_next    = r_reg + 1'b1;
                            done_next = 1'b1;
                            st_next   = pfi_pkg::ST_TIE_KEPT;
                        end
                        else
                        begin
                            // drop the dominated entry
                            r_next = r_reg + 1'b1;
                        end
                    end
                    else if (ea == na)
                    begin
                        we        = 1'b1;
                        w_next    = w_reg + 1'b1;
                        r_next    = r_reg + 1'b1;
                        done_next = 1'b1;
                        st_next   = pfi_pkg::ST_DOMINATED;
                    end
                    else
                    begin
                        we     = 1'b1;
                        w_next = w_reg + 1'b1;
                        r_next = r_reg + 1'b1;
                    end
                end
                else if (eb < nb)
                begin
                    done_next = 1'b1;
                    if (fill_now >= (CNT_W+1)'(CAPACITY))
                    begin
                        we      = 1'b1;
                        w_next  = w_reg + 1'b1;
                        r_next  = r_reg + 1'b1;
                        st_next = pfi_pkg::ST_FULL;
                    end
                    else
                    begin
                        // place new point, reread this entry next pass
                        we      = 1'b1;
                        wdata   = item_reg;
                        w_next  = w_reg + 1'b1;
                        st_next = pfi_pkg::ST_INSERTED;
                    end
                end
                else
                begin
                    we        = 1'b1;
                    w_next    = w_reg + 1'b1;
                    r_next    = r_reg + 1'b1;
                    done_next = 1'b1;
                    st_next   = pfi_pkg::ST_DOMINATED;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    os_next    = st_reg;
                    oc_next    = w_reg;
                    od_next    = '0;
                    ol_next    = 1'b1;
                    cnt_next   = w_reg;
                    bank_next  = ~bank_reg;
                    state_next = S_IDLE;
                end
            end
            S_RO_RD:
            begin
                state_next = S_RO_EV;
            end
            S_RO_EV:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    os_next = pfi_pkg::ST_ENTRY;
                    oc_next = cnt_reg;
                    od_next = rdata_reg;
                    ol_next = (r_reg + 1'b1 == cnt_reg);
                    r_next  = r_reg + 1'b1;
                    state_next = (r_reg + 1'b1 == cnt_reg) ? S_IDLE : S_RO_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bank_reg  <= 1'b0;
            cnt_reg   <= '0;
            r_reg     <= '0;
            w_reg     <= '0;
            done_reg  <= 1'b0;
            st_reg    <= pfi_pkg::ST_INSERTED;
            lfsr_reg  <= pfi_pkg::SEED_DEFAULT;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            cnt_reg   <= cnt_next;
            r_reg     <= r_next;
            w_reg     <= w_next;
            done_reg  <= done_next;
            st_reg    <= st_next;
            lfsr_reg  <= lfsr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        os_reg   <= os_next;
        oc_reg   <= oc_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cnt_reg} <= (CNT_W+1)'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_write_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV) |-> ({1'b0, w_reg} <= {1'b0, r_reg} + 1'b1))
        else $error("write pointer ran ahead of read pointer");

    a_insert_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_free) |=> (ov_reg && ol_reg))
        else $error("insert response missing last marker");

    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("tie-break register locked at zero");

endmodule

// ===== rtl/core/pareto_frontier_2d_insert.sv =====
// Insert: dequeue, then a read state and an evaluate state per stored entry walked,
//   both again for the entry where the point lands mid-table, then append and
//   response; the response waits while the output register is held.
// Readout: a read and an emit state per entry; N words for N entries, none if empty.
// The front queue holds two words, so it takes up to two items while the back walks.
// Reset (rst_n, async, active low): table empty, tie-break register loads 0xACE1,
//   queue and output register empty; table contents stay undefined until written.
module pareto_frontier_2d_insert #(
    parameter int CAPACITY   = pfi_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pfi_pkg::DATA_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pfi_req_if.sink   req,
    pfi_rsp_if.source rsp,
    pfi_cfg_if.sink   cfg
);

    localparam int ITEM_W = 4 * DATA_WIDTH + pfi_pkg::TAG_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    pfi_pkg::item_ctl_t item_ctl;
    logic [ITEM_W-1:0]  item_data;
    logic               item_pop;
    logic [ITEM_W-1:0]  req_data;
    logic [ITEM_W-1:0]  rsp_data;

    // pack the word as key_a, key_b, value_a, value_b, tag
    assign req_data = {req.key_a, req.key_b, req.value_a, req.value_b, req.tag};

    // seed writes are taken at any time
    assign cfg.ready = 1'b1;

    // front: queue and classify incoming words
    pfi_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_op     (req.op),
        .in_data   (req_data),
        .item_ctl  (item_ctl),
        .item_data (item_data),
        .item_pop  (item_pop)
    );

    // back: walk the banked table, compact into the other bank, stream results
    pfi_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .ITEM_W     (ITEM_W),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ctl   (item_ctl),
        .item_data  (item_data),
        .item_pop   (item_pop),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.data),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_count  (rsp.count),
        .out_data   (rsp_data),
        .out_last   (rsp.last)
    );

    // unpack the result word
    assign rsp.out_key_a   = rsp_data[ITEM_W-1 -: DATA_WIDTH];
    assign rsp.out_key_b   = rsp_data[ITEM_W-1-DATA_WIDTH -: DATA_WIDTH];
    assign rsp.out_value_a = rsp_data[ITEM_W-1-2*DATA_WIDTH -: DATA_WIDTH];
    assign rsp.out_value_b = rsp_data[ITEM_W-1-3*DATA_WIDTH -: DATA_WIDTH];
    assign rsp.out_tag     = rsp_data[pfi_pkg::TAG_W-1:0];

endmodule
